// ===== hdl/positional_list_insert_remove_macros.svh =====
// assertion macros for the positional list block
`ifndef POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PLST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/plst_pkg.sv =====
// shared types and constants for the positional list block
package plst_pkg;

    localparam int DEPTH    = 256;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int GRP_SIZE = 16;
    localparam int N_GRP    = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [N_GRP-1:0][DATA_W-1:0] t_grp_vec;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_REM_POS   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // broadcast to every cell of the row
    typedef struct packed {
        logic en;
        logic ins;
        logic rem;
        t_cnt at;
        t_cnt cnt;
    } t_cell_ctrl;

endpackage

// ===== hdl/plst_if.sv =====
// valid/ready channel interfaces for commands and results
interface plst_in_if;
    logic                         valid;
    logic                         ready;
    logic [plst_pkg::CMD_W-1:0]   cmd;
    logic [plst_pkg::POS_W-1:0]   position;
    logic [plst_pkg::DATA_W-1:0]  entry_data;

    modport source (output valid, cmd, position, entry_data, input ready);
    modport sink   (input valid, cmd, position, entry_data, output ready);
endinterface

interface plst_out_if;
    logic                         valid;
    logic                         ready;
    logic [plst_pkg::DATA_W-1:0]  removed_data;
    logic [plst_pkg::STAT_W-1:0]  status;
    logic [plst_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, removed_data, status, entry_count, input ready);
    modport sink   (input valid, removed_data, status, entry_count, output ready);
endinterface

// ===== hdl/plst_cell.sv =====
// one list cell: holds a word, takes the left or right neighbor on a shift
module plst_cell (
    input  logic                 i_clk,
    input  plst_pkg::t_cell_ctrl i_ctrl,
    input  plst_pkg::t_cnt       i_idx,
    input  plst_pkg::t_word      i_new,
    input  plst_pkg::t_word      i_left,
    input  plst_pkg::t_word      i_right,
    output plst_pkg::t_word      o_word,
    output plst_pkg::t_word      o_tap
);

    plst_pkg::t_word r_word;
    plst_pkg::t_word n_word;
    logic            w_hit;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.en && i_ctrl.ins) begin
            if (i_idx == i_ctrl.at) begin
                n_word = i_new;
            end else if ((i_idx > i_ctrl.at) && (i_idx <= i_ctrl.cnt)) begin
                n_word = i_left;
            end
        end else if (i_ctrl.en && i_ctrl.rem) begin
            if ((i_idx >= i_ctrl.at) && ((i_idx + 1'b1) < i_ctrl.cnt)) begin
                n_word = i_right;
            end
        end
    end

    // old word of the removed slot goes out on the tap
    assign w_hit  = i_ctrl.en && i_ctrl.rem && (i_idx == i_ctrl.at);
    assign o_tap  = w_hit ? r_word : '0;
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

// ===== hdl/plst_chain.sv =====
// row of list cells plus the first level of the removed-word collection
module plst_chain (
    input  logic                 i_clk,
    input  plst_pkg::t_cell_ctrl i_ctrl,
    input  plst_pkg::t_word      i_new,
    output plst_pkg::t_grp_vec   o_grp
);

    plst_pkg::t_word    w_word [plst_pkg::DEPTH];
    plst_pkg::t_word    w_tap  [plst_pkg::DEPTH];
    plst_pkg::t_grp_vec r_grp;
    plst_pkg::t_grp_vec n_grp;

    for (genvar i = 0; i < plst_pkg::DEPTH; i++) begin : g_cell
        plst_pkg::t_word w_left;
        plst_pkg::t_word w_right;

        if (i == 0) begin : g_first
            assign w_left = i_new;
        end else begin : g_mid_l
            assign w_left = w_word[i-1];
        end

        if (i == plst_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_word[i];
        end else begin : g_mid_r
            assign w_right = w_word[i+1];
        end

        plst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_idx   (plst_pkg::t_cnt'(i)),
            .i_new   (i_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[i]),
            .o_tap   (w_tap[i])
        );
    end

    // or each group of taps; at most one tap is nonzero
    always_comb begin
        n_grp = '0;
        for (int g = 0; g < plst_pkg::N_GRP; g++) begin
            for (int k = 0; k < plst_pkg::GRP_SIZE; k++) begin
                if (g * plst_pkg::GRP_SIZE + k < plst_pkg::DEPTH) begin
                    n_grp[g] = n_grp[g] | w_tap[g * plst_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_grp <= n_grp;
        end
    end

    assign o_grp = r_grp;

endmodule

// ===== hdl/positional_list_insert_remove.sv =====
// top level of the positional list: command decode, count and result pipeline
//
// i_cmd carries one command per beat: cmd, position and entry_data. o_res
// returns one beat per command: removed_data, status and entry_count.
// every cell of the row updates in the cycle a command is accepted, so a
// new command can be taken each cycle.
// the removed word is gathered from the cells in two registered levels
// of or-reduction, one per group of cells and one across the groups.
// throughput is one command per cycle while o_res keeps taking beats.
// when o_res stalls, one more command is absorbed if the middle stage is
// empty, and then i_cmd.ready drops until the output register is freed.
// an insert into a full list, a remove from an empty list or a position
// out of range leaves the list untouched and returns an error status with
// removed_data zero; codes six and seven do nothing and report ok.
// reset empties the list (count to zero) and drops both pipeline stages;
// stored words are not cleared, since only entries below the count are
// ever read.
`include "positional_list_insert_remove_macros.svh"

module positional_list_insert_remove (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plst_in_if.sink    i_cmd,
    plst_out_if.source o_res
);

    // list count
    plst_pkg::t_cnt       r_cnt;
    plst_pkg::t_cnt       n_cnt;

    // command decode
    logic                 w_accept;
    logic                 w_ready;
    logic                 w_is_ins;
    logic                 w_is_rem;
    logic                 w_ins_ok;
    logic                 w_rem_ok;
    plst_pkg::t_cnt       w_at;
    plst_pkg::t_cnt       w_pos;
    plst_pkg::t_status    w_status;
    plst_pkg::t_cell_ctrl w_ctrl;
    plst_pkg::t_grp_vec   w_grp;
    plst_pkg::t_word      w_removed;

    // middle stage
    logic                 r_s1_vld;
    plst_pkg::t_status    r_s1_status;
    plst_pkg::t_cnt       r_s1_cnt;
    logic                 w_mv;

    // output register
    logic                 r_o_vld;
    plst_pkg::t_word      r_o_removed;
    plst_pkg::t_status    r_o_status;
    plst_pkg::t_cnt       r_o_cnt;

    // middle stage may load when empty or when it hands on this cycle
    assign w_mv     = r_s1_vld && (!r_o_vld || o_res.ready);
    assign w_ready  = !r_s1_vld || !r_o_vld || o_res.ready;
    assign w_accept = i_cmd.valid && w_ready;
    assign w_pos    = plst_pkg::t_cnt'(i_cmd.position);

    // pick the target slot and the kind of command
    always_comb begin
        w_is_ins = 1'b0;
        w_is_rem = 1'b0;
        w_at     = '0;
        unique case (plst_pkg::t_cmd'(i_cmd.cmd))
            plst_pkg::CMD_INS_FRONT: begin
                w_is_ins = 1'b1;
            end
            plst_pkg::CMD_INS_BACK: begin
                w_is_ins = 1'b1;
                w_at     = r_cnt;
            end
            plst_pkg::CMD_INS_POS: begin
                w_is_ins = 1'b1;
                w_at     = w_pos;
            end
            plst_pkg::CMD_REM_FRONT: begin
                w_is_rem = 1'b1;
            end
            plst_pkg::CMD_REM_BACK: begin
                w_is_rem = 1'b1;
                w_at     = r_cnt - 1'b1;
            end
            plst_pkg::CMD_REM_POS: begin
                w_is_rem = 1'b1;
                w_at     = w_pos;
            end
            default: begin
                // unused codes: no change
            end
        endcase
    end

    // full/empty is checked before the position
    always_comb begin
        w_status = plst_pkg::ST_OK;
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        n_cnt    = r_cnt;
        if (w_is_ins) begin
            if (r_cnt == plst_pkg::t_cnt'(plst_pkg::DEPTH)) begin
                w_status = plst_pkg::ST_FULL;
            end else if (w_at > r_cnt) begin
                w_status = plst_pkg::ST_RANGE;
            end else begin
                w_ins_ok = 1'b1;
                n_cnt    = r_cnt + 1'b1;
            end
        end else if (w_is_rem) begin
            if (r_cnt == '0) begin
                w_status = plst_pkg::ST_EMPTY;
            end else if (w_at >= r_cnt) begin
                w_status = plst_pkg::ST_RANGE;
            end else begin
                w_rem_ok = 1'b1;
                n_cnt    = r_cnt - 1'b1;
            end
        end
    end

    assign w_ctrl.en  = w_accept;
    assign w_ctrl.ins = w_ins_ok;
    assign w_ctrl.rem = w_rem_ok;
    assign w_ctrl.at  = w_at;
    assign w_ctrl.cnt = r_cnt;

    plst_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_new  (i_cmd.entry_data),
        .o_grp  (w_grp)
    );

    // second level of the removed-word collection
    always_comb begin
        w_removed = '0;
        for (int g = 0; g < plst_pkg::N_GRP; g++) begin
            w_removed = w_removed | w_grp[g];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt <= n_cnt;
            end
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_mv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_mv) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_cnt    <= n_cnt;
        end
        if (w_mv) begin
            r_o_removed <= w_removed;
            r_o_status  <= r_s1_status;
            r_o_cnt     <= r_s1_cnt;
        end
    end

    assign i_cmd.ready        = w_ready;
    assign o_res.valid        = r_o_vld;
    assign o_res.removed_data = r_o_removed;
    assign o_res.status       = r_o_status;
    assign o_res.entry_count  = r_o_cnt;

    // count never passes the list depth
    `PLST_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= plst_pkg::t_cnt'(plst_pkg::DEPTH), "count above depth")

    // count only moves on an accepted command
    `PLST_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !w_accept, $stable(r_cnt), "count moved without a command")

    // an accepted command moves the count by at most one
    `PLST_ASSERT_NEXT(a_cnt_step, i_clk, i_rst_n, w_accept, (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + 1'b1) || (r_cnt + 1'b1 == $past(r_cnt)), "count step larger than one")

    // failed commands return no data
    `PLST_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_o_vld && (r_o_status != plst_pkg::ST_OK), r_o_removed == '0, "error beat with data")

endmodule

// ===== dv/positional_list_insert_remove_tb.sv =====
// self-checking testbench for the positional list insert/remove block
module positional_list_insert_remove_tb;

    typedef logic [plst_pkg::CMD_W-1:0] t_cmd_code;
    typedef logic [plst_pkg::POS_W-1:0] t_pos;

    // codes six and seven are not in the command enum; the block treats them as no-ops
    localparam t_cmd_code CMD_UNUSED_6 = 3'd6;
    localparam t_cmd_code CMD_UNUSED_7 = 3'd7;

    localparam int IDLE_PCT       = 18;   // chance per cycle that a side idles or stalls
    localparam int WATCHDOG_LIMIT = 2000; // cycles without any accepted beat
    localparam int DRAIN_CYCLES   = 4;    // extra wait after the last expected result beat
    localparam int MAX_REPORTS    = 100;

    // one expected result beat
    typedef struct packed {
        plst_pkg::t_word   removed;
        plst_pkg::t_status status;
        plst_pkg::t_cnt    count;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    plst_in_if  cmd_if ();
    plst_out_if res_if ();

    positional_list_insert_remove u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // shadow copy of the list contents, front at index zero
    plst_pkg::t_word list_words[$];
    t_list_result    expected_results[$];

    bit idle_en = 1'b1;
    int mismatch_cnt = 0;
    int stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    // apply one command to the shadow list and return the beat the block owes for it
    function automatic t_list_result apply_list_cmd(input t_cmd_code c,
                                                    input t_pos p,
                                                    input plst_pkg::t_word d);
        t_list_result r;
        int n;
        int at;
        n = list_words.size();
        r.removed = '0;
        r.status  = plst_pkg::ST_OK;
        case (c)
            plst_pkg::CMD_INS_FRONT, plst_pkg::CMD_INS_BACK, plst_pkg::CMD_INS_POS: begin
                if (c == plst_pkg::CMD_INS_FRONT) at = 0;
                else if (c == plst_pkg::CMD_INS_BACK) at = n;
                else at = int'(p);
                // full is checked ahead of the position
                if (n >= plst_pkg::DEPTH) r.status = plst_pkg::ST_FULL;
                else if (at > n) r.status = plst_pkg::ST_RANGE;
                else if (at == n) list_words.push_back(d);
                else list_words.insert(at, d);
            end
            plst_pkg::CMD_REM_FRONT, plst_pkg::CMD_REM_BACK, plst_pkg::CMD_REM_POS: begin
                if (c == plst_pkg::CMD_REM_FRONT) at = 0;
                else if (c == plst_pkg::CMD_REM_BACK) at = (n == 0) ? 0 : n - 1;
                else at = int'(p);
                // empty is checked ahead of the position
                if (n == 0) r.status = plst_pkg::ST_EMPTY;
                else if (at >= n) r.status = plst_pkg::ST_RANGE;
                else begin
                    r.removed = list_words[at];
                    list_words.delete(at);
                end
            end
            default: ; // unused codes leave everything alone
        endcase
        r.count = plst_pkg::t_cnt'(list_words.size());
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // drive one command beat and hold it until the block takes it
    task automatic send_cmd(input t_cmd_code c, input t_pos p,
                            input plst_pkg::t_word d);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= c;
        cmd_if.position   <= p;
        cmd_if.entry_data <= d;
        do @(posedge i_clk); while (!cmd_if.ready);
        expected_results.push_back(apply_list_cmd(c, p, d));
    endtask

    // random command; ins_pct steers the mix between inserts and removes
    task automatic send_random_cmd(input int ins_pct);
        int n;
        int roll;
        t_cmd_code c;
        t_pos p;
        n    = list_words.size();
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            c = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        end else if (roll < 3 + ins_pct * 97 / 100) begin
            case ($urandom_range(0, 2))
                0:       c = plst_pkg::CMD_INS_FRONT;
                1:       c = plst_pkg::CMD_INS_BACK;
                default: c = plst_pkg::CMD_INS_POS;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       c = plst_pkg::CMD_REM_FRONT;
                1:       c = plst_pkg::CMD_REM_BACK;
                default: c = plst_pkg::CMD_REM_POS;
            endcase
        end
        // mostly legal positions, some anywhere in the 8-bit range
        if ($urandom_range(0, 99) < 15) p = t_pos'($urandom);
        else if (c == plst_pkg::CMD_INS_POS) p = t_pos'($urandom_range(0, (n > 255) ? 255 : n));
        else if (n == 0) p = '0;
        else p = t_pos'($urandom_range(0, n - 1));
        send_cmd(c, p, $urandom);
    endtask

    // every removal flavor and both unused codes on an empty list
    task automatic test_empty_list();
        send_cmd(plst_pkg::CMD_REM_FRONT, 8'd0, 32'h0);
        send_cmd(plst_pkg::CMD_REM_BACK, 8'd0, 32'h0);
        send_cmd(plst_pkg::CMD_REM_POS, 8'd0, 32'hFFFF_FFFF);
        send_cmd(plst_pkg::CMD_REM_POS, 8'd255, 32'h0);
        send_cmd(CMD_UNUSED_6, 8'd255, 32'hFFFF_FFFF);
        send_cmd(CMD_UNUSED_7, 8'd0, 32'h1234_5678);
        // position one past the end of an empty list
        send_cmd(plst_pkg::CMD_INS_POS, 8'd1, 32'hDEAD_BEEF);
    endtask

    // data extremes, appends by position, middle shifts and range errors
    task automatic test_edge_positions();
        send_cmd(plst_pkg::CMD_INS_FRONT, 8'd0, 32'h0000_0000);
        send_cmd(plst_pkg::CMD_INS_BACK, 8'd0, 32'hFFFF_FFFF);
        send_cmd(plst_pkg::CMD_INS_POS, 8'd2, 32'hA5A5_A5A5);   // position equal to count appends
        send_cmd(plst_pkg::CMD_INS_POS, 8'd0, 32'h5A5A_5A5A);
        send_cmd(plst_pkg::CMD_INS_POS, 8'd2, 32'h1234_5678);   // middle insert shifts the tail up
        send_cmd(plst_pkg::CMD_INS_POS, 8'd255, 32'hCAFE_F00D);
        send_cmd(plst_pkg::CMD_REM_POS, 8'd5, 32'h0);   // position equal to count is out of range
        send_cmd(plst_pkg::CMD_REM_POS, 8'd255, 32'h0);
        send_cmd(plst_pkg::CMD_REM_POS, 8'd2, 32'hFFFF_FFFF);   // middle remove shifts the tail down
        send_cmd(CMD_UNUSED_7, 8'd1, 32'hFFFF_FFFF);
        send_cmd(plst_pkg::CMD_REM_BACK, 8'd0, 32'h0);
        send_cmd(plst_pkg::CMD_REM_FRONT, 8'd0, 32'h0);
        send_cmd(plst_pkg::CMD_REM_POS, 8'd0, 32'h0);
        send_cmd(plst_pkg::CMD_REM_POS, 8'd0, 32'h0);
    endtask

    task automatic test_random_mix();
        repeat (60) send_random_cmd(55);
    endtask

    // inserts and unused codes until the row is full, then mostly inserts to keep hitting the full case
    task automatic test_fill_to_full();
        while (list_words.size() < plst_pkg::DEPTH) send_random_cmd(100);
        repeat (10) send_random_cmd(90);
    endtask

    // back-to-back beats with both sides always ready, list near full
    task automatic test_steady_no_idle();
        idle_en = 1'b0;
        repeat (60) send_random_cmd(50);
        idle_en = 1'b1;
    endtask

    // remove-heavy stretch down from a nearly full list
    task automatic test_remove_heavy();
        repeat (30) send_random_cmd(5);
    endtask

    // result sink: stalls at random unless idling is switched off
    always @(posedge i_clk)
        res_if.ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);

    // compare every accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, count %0d",
                                          res_if.entry_count));
            end else begin
                want = expected_results.pop_front();
                if (res_if.removed_data !== want.removed)
                    report_mismatch($sformatf("removed_data %h, expected %h",
                                              res_if.removed_data, want.removed));
                if (res_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              res_if.status, want.status.name()));
                if (res_if.entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              res_if.entry_count, want.count));
            end
        end
    end

    // watchdog: any accepted beat on either channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = '0;
        cmd_if.position   = '0;
        cmd_if.entry_data = '0;
        res_if.ready      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edge_positions();
        test_random_mix();
        test_fill_to_full();
        test_steady_no_idle();
        test_remove_heavy();

        cmd_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
